/* hdl/ssh_plaintext_packet_deframer_assert.svh */
// Assertion helpers used by the deframer checker.
`ifndef SSH_PLAINTEXT_PACKET_DEFRAMER_ASSERT_SVH
`define SSH_PLAINTEXT_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("deframer assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define SPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("deframer assertion failed (next cycle)");

`endif

/* hdl/spd_pkg.sv */
`default_nettype none
package spd_pkg;

  // Result kinds, carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_TOO_BIG  = 2'd1,
    KIND_PROTOCOL = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_e;

  // Receive phases.
  localparam logic [2:0] PH_LENGTH        = 3'd0;
  localparam logic [2:0] PH_PADLEN        = 3'd1;
  localparam logic [2:0] PH_PAYLOAD       = 3'd2;
  localparam logic [2:0] PH_PADDING       = 3'd3;
  localparam logic [2:0] PH_PADDING_EMPTY = 3'd4;
  localparam logic [2:0] PH_HALT          = 3'd5;

  localparam logic [31:0] MIN_PACKET_LENGTH = 32'd5;
  localparam logic [15:0] MAX_LEN_RESET     = 16'd1024;

  // Configuration register map.
  localparam int unsigned PADDR_W = 3;
  localparam logic [0:0]  REG_MAX_LEN = 1'b0;

  // One result word from the core to the output register.
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] seq;
  } res_t;

endpackage
`default_nettype wire

/* hdl/ssh_plaintext_packet_deframer.sv */
// Channel   Dir  Data                                      Sideband
// s_axis    in   tdata[7:0] rx_byte                        -
// m_axis    out  tdata[7:0] payload_byte, [39:8] sequence  tuser[1:0] kind, tlast
// apb       in   register 0 at address 0: max_packet_length (16 bits)
//
// One received word per cycle unless the output stalls: a word is held in the input
// register, and its result (if any) is loaded into the output register as it is consumed.
// The per-word step is a counter update and a 32-bit compare in the core.
// Reset clears all packet state, the sequence count and the error halt.
// A stalled output register holds its word; the input keeps flowing while
// the output register is free or being taken in the same cycle.
`default_nettype none
module ssh_plaintext_packet_deframer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [39:0]                      m_axis_tdata,   // [7:0] payload_byte, [39:8] packet_sequence
  output logic [1:0]                       m_axis_tuser,   // [1:0] kind
  output logic                             m_axis_tlast,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic          in_valid_q, in_valid_d;
  logic [7:0]    in_byte_q;
  logic          out_valid_q, out_valid_d;
  spd_pkg::res_t out_q;
  spd_pkg::res_t res;
  logic [15:0]   max_len_q;
  logic          consume;
  logic          reg_hit;

  assign consume       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || consume;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (consume && res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  spd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (consume),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (consume && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.seq, out_q.data};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  // Configuration: only the top address bit is decoded; the low address bits are ignored.
  assign reg_hit = (paddr[spd_pkg::PADDR_W-1] == spd_pkg::REG_MAX_LEN);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {16'd0, max_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= spd_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_len_q <= pwdata[15:0];
    end
  end

endmodule
`default_nettype wire

/* hdl/spd_core.sv */
`default_nettype none
module spd_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   byte_i,
  input  wire logic [15:0]  max_len_i,
  output spd_pkg::res_t     res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  pad_q, pad_d;
  logic [15:0] pay_q, pay_d;
  logic [31:0] seq_q, seq_d;

  logic [31:0] len_shift;
  logic [31:0] pad_plus_one;
  logic [15:0] pay_calc;

  assign len_shift    = {len_q[23:0], byte_i};
  assign pad_plus_one = {24'd0, byte_i} + 32'd1;
  // The length is already known to fit in 16 bits once the header passed.
  assign pay_calc     = len_q[15:0] - 16'd1 - {8'd0, byte_i};

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    len_d     = len_q;
    pad_d     = pad_q;
    pay_d     = pay_q;
    seq_d     = seq_q;
    res_o       = '0;
    res_o.kind  = spd_pkg::KIND_BYTE;
    res_o.seq   = seq_q;
    if (step_i) begin
      unique case (phase_q) inside
        spd_pkg::PH_LENGTH: begin
          len_d     = len_shift;
          hdr_cnt_d = hdr_cnt_q + 2'd1;
          if (hdr_cnt_q == 2'd3) begin
            if (len_shift < spd_pkg::MIN_PACKET_LENGTH ||
                len_shift > {16'd0, max_len_i}) begin
              res_o.valid = 1'b1;
              res_o.kind  = spd_pkg::KIND_TOO_BIG;
              phase_d     = spd_pkg::PH_HALT;
            end else begin
              phase_d = spd_pkg::PH_PADLEN;
            end
          end
        end
        spd_pkg::PH_PADLEN: begin
          if (pad_plus_one > len_q) begin
            res_o.valid = 1'b1;
            res_o.kind  = spd_pkg::KIND_PROTOCOL;
            phase_d     = spd_pkg::PH_HALT;
          end else begin
            pad_d   = byte_i;
            pay_d   = pay_calc;
            phase_d = (pay_calc == 16'd0) ? spd_pkg::PH_PADDING_EMPTY
                                          : spd_pkg::PH_PAYLOAD;
          end
        end
        spd_pkg::PH_PAYLOAD: begin
          pay_d       = pay_q - 16'd1;
          res_o.valid = 1'b1;
          res_o.data  = byte_i;
          if (pay_q == 16'd1) begin
            res_o.last = 1'b1;
            if (pad_q == 8'd0) begin
              seq_d     = seq_q + 32'd1;
              phase_d   = spd_pkg::PH_LENGTH;
              hdr_cnt_d = 2'd0;
              len_d     = '0;
            end else begin
              phase_d = spd_pkg::PH_PADDING;
            end
          end
        end
        spd_pkg::PH_PADDING, spd_pkg::PH_PADDING_EMPTY: begin
          pad_d = pad_q - 8'd1;
          if (pad_q == 8'd1) begin
            if (phase_q == spd_pkg::PH_PADDING_EMPTY) begin
              res_o.valid = 1'b1;
              res_o.kind  = spd_pkg::KIND_EMPTY;
            end
            seq_d     = seq_q + 32'd1;
            phase_d   = spd_pkg::PH_LENGTH;
            hdr_cnt_d = 2'd0;
            len_d     = '0;
          end
        end
        default: begin
          // Halted after an error: words are swallowed until reset.
          phase_d = spd_pkg::PH_HALT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= spd_pkg::PH_LENGTH;
      hdr_cnt_q <= '0;
      len_q     <= '0;
      pad_q     <= '0;
      pay_q     <= '0;
      seq_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      len_q     <= len_d;
      pad_q     <= pad_d;
      pay_q     <= pay_d;
      seq_q     <= seq_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/spd_checker.sv */
`default_nettype none
`include "ssh_plaintext_packet_deframer_assert.svh"
module spd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [39:0]                 m_axis_tdata,
  input wire logic [1:0]                  m_axis_tuser,
  input wire logic                        m_axis_tlast,
  input wire logic                        psel,
  input wire logic                        pready
);

  logic is_byte;
  logic is_error;

  assign is_byte  = (m_axis_tuser == spd_pkg::KIND_BYTE);
  assign is_error = (m_axis_tuser == spd_pkg::KIND_TOO_BIG) ||
                    (m_axis_tuser == spd_pkg::KIND_PROTOCOL);

  // A stalled word keeps its contents.
  `SPD_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // Only payload words carry a byte or the end-of-payload mark.
  `SPD_ASSERT_IMP(a_nonbyte_clean, clk_i, rst_ni, m_axis_tvalid && !is_byte, m_axis_tdata[7:0] == 8'd0 && !m_axis_tlast)

  // An error is the last word ever given until reset.
  `SPD_ASSERT_NXT(a_error_final, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && is_error, !m_axis_tvalid)

  // The register port never stalls.
  `SPD_ASSERT_IMP(a_apb_ready, clk_i, rst_ni, psel, pready)

endmodule

bind ssh_plaintext_packet_deframer spd_checker u_spd_checker (.*);
`default_nettype wire

/* tb/ssh_plaintext_packet_deframer_tb.sv */
`timescale 1ns / 100ps
module ssh_plaintext_packet_deframer_tb;

  localparam int unsigned MISMATCH_SHOWN = 10;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT    = 1_500_000;
  localparam int unsigned RANDOM_BYTES   = 600;
  localparam int unsigned IDLE_PERCENT   = 31;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam logic [spd_pkg::PADDR_W-1:0] MAX_LEN_ADDR = {spd_pkg::REG_MAX_LEN, 2'b00};

  typedef enum logic [1:0] {
    ERR_SHORT,
    ERR_OVER_MAX,
    ERR_PADDING,
    ERR_ZERO_LIMIT
  } halt_cause_e;

  typedef struct packed {
    spd_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
    logic [31:0]    seq;
  } deframed_word_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata  = 8'd0;   // [7:0] rx_byte
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [39:0]                  m_axis_tdata;  // [7:0] payload_byte, [39:8] packet_sequence
  logic [1:0]                   m_axis_tuser;           // [1:0] kind
  logic                         m_axis_tlast;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [spd_pkg::PADDR_W-1:0]  paddr         = '0;
  logic [31:0]                  pwdata        = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // Deframer prediction state.
  logic [15:0] limit_len;
  logic [2:0]  rx_phase;
  logic [1:0]  hdr_count;
  logic [31:0] len_field;
  logic [7:0]  pad_left;
  logic [15:0] body_left;
  logic [31:0] seq_count;
  logic        halted;

  deframed_word_t expected_words[$];
  int unsigned    fail_count  = 0;
  int unsigned    bytes_sent  = 0;
  bit             idle_on     = 1'b1;
  int unsigned    hold_cycles = 0;
  int unsigned    held        = 0;

  ssh_plaintext_packet_deframer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function void note_mismatch(input string what, input logic [39:0] want,
                              input logic [39:0] got);
    fail_count++;
    if (fail_count <= MISMATCH_SHOWN) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  function void clear_deframer();
    limit_len = spd_pkg::MAX_LEN_RESET;
    rx_phase  = spd_pkg::PH_LENGTH;
    hdr_count = 2'd0;
    len_field = 32'd0;
    pad_left  = 8'd0;
    body_left = 16'd0;
    seq_count = 32'd0;
    halted    = 1'b0;
  endfunction

  function void close_packet();
    seq_count = seq_count + 32'd1;
    rx_phase  = spd_pkg::PH_LENGTH;
    hdr_count = 2'd0;
    len_field = 32'd0;
  endfunction

  // Advances the deframer by one received byte and queues the word it yields.
  function void deframe_byte(input logic [7:0] b);
    deframed_word_t w;
    if (halted) begin
      return;
    end
    w.kind = spd_pkg::KIND_BYTE;
    w.data = 8'd0;
    w.last = 1'b0;
    w.seq  = seq_count;
    case (rx_phase)
      spd_pkg::PH_LENGTH: begin
        len_field = {len_field[23:0], b};
        hdr_count = hdr_count + 2'd1;
        if (hdr_count == 2'd0) begin
          if (len_field < spd_pkg::MIN_PACKET_LENGTH || len_field > {16'd0, limit_len}) begin
            w.kind = spd_pkg::KIND_TOO_BIG;
            expected_words.push_back(w);
            halted   = 1'b1;
            rx_phase = spd_pkg::PH_HALT;
          end else begin
            rx_phase = spd_pkg::PH_PADLEN;
          end
        end
      end
      spd_pkg::PH_PADLEN: begin
        if ({24'd0, b} + 32'd1 > len_field) begin
          w.kind = spd_pkg::KIND_PROTOCOL;
          expected_words.push_back(w);
          halted   = 1'b1;
          rx_phase = spd_pkg::PH_HALT;
        end else begin
          pad_left  = b;
          body_left = 16'(len_field - 32'd1 - {24'd0, b});
          rx_phase  = (body_left == 16'd0) ? spd_pkg::PH_PADDING_EMPTY
                                           : spd_pkg::PH_PAYLOAD;
        end
      end
      spd_pkg::PH_PAYLOAD: begin
        body_left = body_left - 16'd1;
        w.data = b;
        w.last = (body_left == 16'd0);
        expected_words.push_back(w);
        if (w.last) begin
          if (pad_left == 8'd0) begin
            close_packet();
          end else begin
            rx_phase = spd_pkg::PH_PADDING;
          end
        end
      end
      spd_pkg::PH_PADDING: begin
        pad_left = pad_left - 8'd1;
        if (pad_left == 8'd0) begin
          close_packet();
        end
      end
      spd_pkg::PH_PADDING_EMPTY: begin
        pad_left = pad_left - 8'd1;
        if (pad_left == 8'd0) begin
          w.kind = spd_pkg::KIND_EMPTY;
          expected_words.push_back(w);
          close_packet();
        end
      end
      default: begin
        halted   = 1'b1;
        rx_phase = spd_pkg::PH_HALT;
      end
    endcase
  endfunction

  // Prediction runs before the check so a word is always queued ahead of its result.
  always @(posedge clk_i) begin
    deframed_word_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          note_mismatch("unexpected word", 40'd0, {m_axis_tuser, m_axis_tdata[37:0]});
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tuser !== want.kind) begin
            note_mismatch("kind", 40'(want.kind), 40'(m_axis_tuser));
          end
          if (m_axis_tdata[7:0] !== want.data) begin
            note_mismatch("payload_byte", 40'(want.data), 40'(m_axis_tdata[7:0]));
          end
          if (m_axis_tlast !== want.last) begin
            note_mismatch("last_of_payload", 40'(want.last), 40'(m_axis_tlast));
          end
          if (m_axis_tdata[39:8] !== want.seq) begin
            note_mismatch("packet_sequence", 40'(want.seq), 40'(m_axis_tdata[39:8]));
          end
        end
      end
    end
  end

  // Output side: random stalls, plus a long hold-off when a test asks for one.
  always @(negedge clk_i) begin
    if (held < hold_cycles) begin
      m_axis_tready <= 1'b0;
      held <= held + 1;
    end else begin
      m_axis_tready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("ssh_plaintext_packet_deframer regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_header(input logic [31:0] length, input logic [7:0] pad);
    for (int i = 3; i >= 0; i--) begin
      send_byte(length[8*i +: 8]);
    end
    send_byte(pad);
  endtask

  task automatic send_packet(input logic [31:0] length, input logic [7:0] pad);
    send_header(length, pad);
    for (int unsigned i = 1; i < length; i++) begin
      send_byte(8'($urandom));
    end
  endtask

  // Bytes that yield no word may still be in flight once the queue is empty.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_max_length(input logic [15:0] value);
    logic [31:0] got;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= {16'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    limit_len = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[15:0] !== value) begin
      note_mismatch("max_packet_length readback", 40'(value), 40'(got[15:0]));
    end
  endtask

  task automatic test_directed_packets();
    send_packet(32'd5, 8'd4);
    send_header(32'd5, 8'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_packet(32'd6, 8'd4);
    wait_idle();
  endtask

  task automatic test_length_limits();
    write_max_length(16'd64);
    send_packet(32'd64, 8'd0);
    write_max_length(16'(spd_pkg::MIN_PACKET_LENGTH));
    send_packet(32'd5, 8'd0);
    send_packet(32'd5, 8'd4);
    write_max_length(16'hFFFF);
    send_packet(32'd260, 8'd255);
    write_max_length(16'($urandom_range(65535, 5)));
    write_max_length(spd_pkg::MAX_LEN_RESET);
  endtask

  task automatic test_random_packets();
    int unsigned start_count;
    int unsigned pkt;
    int unsigned cap;
    int unsigned top;
    int unsigned max_pad;
    int unsigned pick;
    logic [31:0] length;
    logic [7:0]  pad;
    start_count = bytes_sent;
    pkt = 0;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      // A stretch in the middle runs with neither side idling.
      idle_on = !(bytes_sent - start_count >= 200 && bytes_sent - start_count < 400);
      if (pkt % 12 == 11) begin
        pick = $urandom_range(4);
        if (pick == 0) begin
          write_max_length(16'(spd_pkg::MIN_PACKET_LENGTH));
        end else if (pick == 1) begin
          write_max_length(16'($urandom_range(100, 6)));
        end else if (pick == 2) begin
          write_max_length(spd_pkg::MAX_LEN_RESET);
        end else if (pick == 3) begin
          write_max_length(16'hFFFF);
        end else begin
          write_max_length(16'($urandom_range(65535, 5)));
        end
      end
      cap     = ($urandom_range(9) == 0) ? 400 : 40;
      top     = (limit_len < cap) ? limit_len : cap;
      length  = $urandom_range(top, 5);
      max_pad = (length - 1 > 255) ? 255 : length - 1;
      pick    = $urandom_range(9);
      if (pick < 2) begin
        pad = 8'(max_pad);
      end else if (pick < 3) begin
        pad = 8'd0;
      end else begin
        pad = 8'($urandom_range(max_pad, 0));
      end
      send_packet(length, pad);
      pkt++;
    end
    idle_on = 1'b1;
    wait_idle();
  endtask

  // The output holds off while the sender keeps offering payload bytes.
  task automatic test_output_holdoff();
    idle_on = 1'b0;
    write_max_length(spd_pkg::MAX_LEN_RESET);
    @(posedge clk_i);
    hold_cycles = held + HOLD_CYCLES;
    @(negedge clk_i);
    send_packet(32'd120, 8'd8);
    send_packet(32'd40, 8'd0);
    idle_on = 1'b1;
    wait_idle();
  endtask

  // An error halts the block for the rest of the run, so one cause is picked here.
  task automatic test_halt_on_error();
    halt_cause_e cause;
    logic [31:0] length;
    cause = halt_cause_e'($urandom_range(3));
    case (cause)
      ERR_SHORT: begin
        send_header(32'($urandom_range(4)), 8'($urandom));
      end
      ERR_OVER_MAX: begin
        if ($urandom_range(1) == 0) begin
          length = {16'($urandom_range(65535, 1)), 16'($urandom)};
        end else begin
          length = 32'(limit_len) + 32'($urandom_range(100, 1));
        end
        send_header(length, 8'($urandom));
      end
      ERR_PADDING: begin
        write_max_length(spd_pkg::MAX_LEN_RESET);
        length = $urandom_range(254, 5);
        send_header(length, 8'($urandom_range(255, length)));
      end
      default: begin
        write_max_length(16'($urandom_range(4)));
        send_packet(32'($urandom_range(40, 5)), 8'd0);
      end
    endcase
    for (int i = 0; i < 30; i++) begin
      send_byte(8'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    clear_deframer();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_packets();
    test_length_limits();
    test_random_packets();
    test_output_holdoff();
    test_halt_on_error();
    wait_idle();
    if (expected_words.size() != 0) begin
      note_mismatch("missing words", 40'd0, 40'(expected_words.size()));
    end
    if (fail_count == 0) begin
      $display("ssh_plaintext_packet_deframer regression: pass");
    end else begin
      $display("ssh_plaintext_packet_deframer regression: fail");
    end
    $finish;
  end

endmodule
